@@ rtl/rsca_pkg.sv @@
`default_nettype none

package rsca_pkg;

   // Table depth used when the top level is not overridden
   localparam int TABLE_DEPTH_DEF = 64;

   // Address and report widths
   localparam int ADDR_W  = 64;
   localparam int COUNT_W = 7;

   // Operation codes
   localparam logic KIND_CLEAR  = 1'b0;
   localparam logic KIND_APPEND = 1'b1;

   // Outcome of comparing one stored entry against the request range
   typedef struct packed {
      logic overlap;   // entry and range share at least one address
      logic head;      // entry starts below the range
      logic tail;      // entry ends above the range
   } cmp_res_type;

endpackage

`default_nettype wire

@@ rtl/rsca_chan_if.sv @@
`default_nettype none

// Request channel: operation and range
interface rsca_req_if
   import rsca_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] range_lo;
   logic [ADDR_W-1:0] range_hi;

   modport source (output valid, kind, range_lo, range_hi, input ready);
   modport sink   (input valid, kind, range_lo, range_hi, output ready);
endinterface

// Response channel: status after the operation
interface rsca_rsp_if
   import rsca_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               changed;
   logic [COUNT_W-1:0] entry_count;
   logic               fail_closed;

   modport source (output valid, changed, entry_count, fail_closed, input ready);
   modport sink   (input valid, changed, entry_count, fail_closed, output ready);
endinterface

`default_nettype wire

@@ rtl/rsca_table.sv @@
`default_nettype none

// Range table storage: one write port, one registered read port
module rsca_table
   import rsca_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_idx,
   input  wire logic [ADDR_W-1:0] wr_start,
   input  wire logic [ADDR_W-1:0] wr_end,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_idx,
   output      logic [ADDR_W-1:0] rd_start,
   output      logic [ADDR_W-1:0] rd_end
);

   logic [ADDR_W-1:0] start_mem [DEPTH];
   logic [ADDR_W-1:0] end_mem   [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_idx] <= wr_start;
         end_mem[wr_idx]   <= wr_end;
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_start <= start_mem[rd_idx];
         rd_end   <= end_mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

@@ rtl/rsca_cmp.sv @@
`default_nettype none

// Shared compare unit: classifies one entry against the request range
module rsca_cmp
   import rsca_pkg::*;
(
   input  wire logic [ADDR_W-1:0] range_lo,
   input  wire logic [ADDR_W-1:0] range_hi,
   input  wire logic [ADDR_W-1:0] ent_start,
   input  wire logic [ADDR_W-1:0] ent_end,
   output      cmp_res_type       res
);

   always_comb begin
      res.overlap = !((range_lo >= ent_end) || (range_hi <= ent_start));
      res.head    = ent_start < range_lo;
      res.tail    = range_hi < ent_end;
   end

endmodule

`default_nettype wire

@@ rtl/range_set_clear_append.sv @@
`default_nettype none

// Channel  Dir  Handshake     Payload
// req      in   valid/ready   kind, range_lo, range_hi
// rsp      out  valid/ready   changed, entry_count, fail_closed
//
// One request at a time. An empty or inverted range gets its response in the cycle
// after acceptance. Otherwise each entry examined takes a table read (or a move of
// the last entry), then a compare; a split adds a tail append (the tail is examined
// too), and the walk ends with a final check with the append, then the response.
// The single read port of the table with its registered output sets the pace.
// Reset clears the count, the fail flag and the sequencer; table contents are not
// cleared, only entries below the count are read.
// A waiting response holds until taken; no request is accepted meanwhile.
module range_set_clear_append
   import rsca_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   rsca_req_if.sink   req_chan,
   rsca_rsp_if.source rsp_chan
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_MOVE = 3'd3;
   localparam logic [2:0] S_PUSH = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              flag_ff, flag_in;
   logic              changed_ff, changed_in;
   logic              kind_ff, kind_in;
   logic [ADDR_W-1:0] lo_ff, lo_in;
   logic [ADDR_W-1:0] hi_ff, hi_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [ADDR_W-1:0] wr_start;
   logic [ADDR_W-1:0] wr_end;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;
   logic [ADDR_W-1:0] rd_start;
   logic [ADDR_W-1:0] rd_end;
   cmp_res_type       cmp;

   logic [CNT_W-1:0]  cnt_dec;
   logic              has_room;
   logic              req_fire;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;

   rsca_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_start (wr_start),
      .wr_end   (wr_end),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx),
      .rd_start (rd_start),
      .rd_end   (rd_end)
   );

   rsca_cmp u_cmp (
      .range_lo  (lo_ff),
      .range_hi  (hi_ff),
      .ent_start (rd_start),
      .ent_end   (rd_end),
      .res       (cmp)
   );

   assign cnt_dec  = cnt_ff - 1'b1;
   assign has_room = cnt_ff < CNT_W'(TABLE_DEPTH);
   assign req_fire = req_chan.valid && req_chan.ready;

   // handshake and response fields
   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = (state_ff == S_RESP);
   assign rsp_chan.changed     = changed_ff;
   assign cnt_ext              = {{COUNT_W{1'b0}}, cnt_ff};
   assign rsp_chan.entry_count = cnt_ext[COUNT_W-1:0];
   assign rsp_chan.fail_closed = flag_ff;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      flag_in    = flag_ff;
      changed_in = changed_ff;
      kind_in    = kind_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      wr_en      = 1'b0;
      wr_idx     = idx_ff[IDX_W-1:0];
      wr_start   = rd_start;
      wr_end     = rd_end;
      rd_en      = 1'b0;
      rd_idx     = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in    = req_chan.kind;
               lo_in      = req_chan.range_lo;
               hi_in      = req_chan.range_hi;
               changed_in = 1'b0;
               idx_in     = '0;
               state_in   = (req_chan.range_hi > req_chan.range_lo) ? S_READ : S_RESP;
            end
         end
         S_READ: begin
            if (idx_ff < cnt_ff) begin
               rd_en    = 1'b1;
               state_in = S_EVAL;
            end else begin
               // walk done: an append stores its own range now
               if (kind_ff == KIND_APPEND) begin
                  if (has_room) begin
                     wr_en    = 1'b1;
                     wr_idx   = cnt_ff[IDX_W-1:0];
                     wr_start = lo_ff;
                     wr_end   = hi_ff;
                     cnt_in   = cnt_ff + 1'b1;
                  end else begin
                     flag_in = 1'b1;
                  end
               end
               state_in = S_RESP;
            end
         end
         S_EVAL: begin
            if (!cmp.overlap) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end else begin
               changed_in = 1'b1;
               if (!cmp.head && !cmp.tail) begin
                  // fully covered: pull the last entry into this slot
                  cnt_in = cnt_dec;
                  if (idx_ff == cnt_dec) begin
                     state_in = S_READ;
                  end else begin
                     rd_en    = 1'b1;
                     rd_idx   = cnt_dec[IDX_W-1:0];
                     state_in = S_MOVE;
                  end
               end else begin
                  // trim one end; a straddle keeps the head here
                  wr_en = 1'b1;
                  if (cmp.head) begin
                     wr_end = lo_ff;
                  end else begin
                     wr_start = hi_ff;
                  end
                  if (cmp.head && cmp.tail) begin
                     state_in = S_PUSH;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
            end
         end
         S_MOVE: begin
            // moved entry stays in the read register and is examined again
            wr_en    = 1'b1;
            state_in = S_EVAL;
         end
         S_PUSH: begin
            // append the tail of a split entry
            if (has_room) begin
               wr_en    = 1'b1;
               wr_idx   = cnt_ff[IDX_W-1:0];
               wr_start = hi_ff;
               cnt_in   = cnt_ff + 1'b1;
            end else begin
               flag_in = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_READ;
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         idx_ff     <= '0;
         cnt_ff     <= '0;
         flag_ff    <= 1'b0;
         changed_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         flag_ff    <= flag_in;
         changed_ff <= changed_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
   end

`ifndef ASSERT_OFF
   // table never holds more entries than it has slots
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // walk index never passes the entry count
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= cnt_ff)
      else $error("walk index beyond entry count");

   // fail flag is sticky
   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      flag_ff |=> flag_ff)
      else $error("fail flag dropped");

   // never ready for a request while a response is pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request accepted while response pending");

   // count holds while idle or while a response waits
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_RESP) |=> $stable(cnt_ff) || $past(reset))
      else $error("entry count changed outside a walk");
`endif

endmodule

`default_nettype wire
